>>> sv/cdss_pkg.sv
// Shared types, constants and trig table for the contact density speed sweep.
// Used by every module of the block; depends on nothing.
package cdss_pkg;

  localparam int MAX_CONTACTS  = 16;
  localparam int MAX_SIM_STEPS = 4096;
  localparam int K_W           = $clog2(MAX_CONTACTS);

  localparam int T_MAX = 60;
  localparam int D_MAX = 10000;
  localparam int M_MAX = 64;

  localparam int I_W   = $clog2(MAX_SIM_STEPS + 2);
  localparam int IT_W  = $clog2((MAX_SIM_STEPS + 1) * T_MAX + 1);
  localparam int PJ_W  = $clog2(T_MAX * M_MAX + 1);
  localparam int ITJ_W = $clog2((MAX_SIM_STEPS + 1) * T_MAX * M_MAX + 1);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 5;

  localparam logic [4:0] NO_SLOT = 5'd16;

  localparam logic [63:0] DEG_TO_RAD_Q30 = 64'd18740330;
  localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

  typedef enum logic [2:0] {
    REG_OWN_X,
    REG_OWN_Y,
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_TIME_STEP,
    REG_DENSITY,
    REG_MAX_SPEED
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [5:0]         time_step_s;
    logic [13:0]        density_range_m;
    logic [6:0]         max_speed_tenths;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SQ_GX,
    OP_SQ_GY,
    OP_SQRT_LD,
    OP_SQRT_STEP,
    OP_SET_R,
    OP_SPEED_INIT,
    OP_MUL_OX,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_SET_OX,
    OP_SET_OY,
    OP_CONTACT,
    OP_MUL_V,
    OP_MUL_MX,
    OP_MUL_MY,
    OP_DELTA,
    OP_DELTA_Y,
    OP_SQ_AX,
    OP_SQ_AY,
    OP_RNG_UPDATE,
    OP_NEXT,
    OP_STEP_ADV,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
    logic step_end;
    logic slot_ok;
    logic in_box;
    logic last_contact;
    logic last_speed;
    logic out_free;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_GX,
    ST_SQ_GY,
    ST_R_SQRT_LD,
    ST_R_SQRT,
    ST_SET_R,
    ST_SPEED_INIT,
    ST_STEP_CHECK,
    ST_MUL_OX,
    ST_DIV_OX_LD,
    ST_DIV_OX,
    ST_SET_OX,
    ST_DIV_OY_LD,
    ST_DIV_OY,
    ST_SET_OY,
    ST_CONTACT,
    ST_MUL_V,
    ST_MUL_MX,
    ST_MUL_MY,
    ST_DELTA,
    ST_DELTA_Y,
    ST_SQ_AX,
    ST_SQ_AY,
    ST_C_SQRT_LD,
    ST_C_SQRT,
    ST_RNG_UPDATE,
    ST_NEXT,
    ST_STEP_ADV,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } trig_t;

  typedef logic [14:0] sin_tab_t [0:90];

  function automatic logic [14:0] sin_quarter(input int unsigned d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    x  = 64'(d) * DEG_TO_RAD_Q30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    y  = (((x * t) >> 30) + (64'd1 << 15)) >> 16;
    return y[14:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    int unsigned d;
    for (d = 0; d <= 90; d++) begin
      tab[d] = sin_quarter(d);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // sine of a heading in degrees, heading below 720
  function automatic trig_t sin_deg(input logic [9:0] h);
    logic [9:0] hh;
    logic [9:0] q;
    trig_t      res;
    hh = (h >= 10'd360) ? h - 10'd360 : h;
    if (hh <= 10'd90) begin
      q = hh;
      res.neg = 1'b0;
    end else if (hh <= 10'd180) begin
      q = 10'd180 - hh;
      res.neg = 1'b0;
    end else if (hh <= 10'd270) begin
      q = hh - 10'd180;
      res.neg = 1'b1;
    end else begin
      q = 10'd360 - hh;
      res.neg = 1'b1;
    end
    res.mag = SIN_TAB[q[6:0]];
    return res;
  endfunction

endpackage

>>> sv/cdss_regs.sv
// APB configuration registers for the contact density speed sweep.
// Depends on cdss_pkg for the register map and the configuration struct.
module cdss_regs import cdss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_x            <= '0;
      cfg.own_y            <= '0;
      cfg.goal_x           <= '0;
      cfg.goal_y           <= '0;
      cfg.time_step_s      <= 6'd1;
      cfg.density_range_m  <= 14'd50;
      cfg.max_speed_tenths <= 7'd50;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_OWN_X:     cfg.own_x            <= pwdata;
        REG_OWN_Y:     cfg.own_y            <= pwdata;
        REG_GOAL_X:    cfg.goal_x           <= pwdata;
        REG_GOAL_Y:    cfg.goal_y           <= pwdata;
        REG_TIME_STEP: cfg.time_step_s      <= pwdata[5:0];
        REG_DENSITY:   cfg.density_range_m  <= pwdata[13:0];
        REG_MAX_SPEED: cfg.max_speed_tenths <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OWN_X:     prdata = cfg.own_x;
      REG_OWN_Y:     prdata = cfg.own_y;
      REG_GOAL_X:    prdata = cfg.goal_x;
      REG_GOAL_Y:    prdata = cfg.goal_y;
      REG_TIME_STEP: prdata = {26'd0, cfg.time_step_s};
      REG_DENSITY:   prdata = {18'd0, cfg.density_range_m};
      REG_MAX_SPEED: prdata = {25'd0, cfg.max_speed_tenths};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> sv/cdss_ctrl.sv
// Sequencer of the contact density speed sweep: walks speeds, steps and slots.
// Depends on cdss_pkg; drives cdss_dp through cmd_t and reads status_t.
module cdss_ctrl import cdss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_op,
  input  status_t status,
  output logic    s_tready,
  output cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_op) begin
            cmd.op     = OP_START;
            state_next = ST_SQ_GX;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      ST_SQ_GX: begin
        cmd.op     = OP_SQ_GX;
        state_next = ST_SQ_GY;
      end
      ST_SQ_GY: begin
        cmd.op     = OP_SQ_GY;
        state_next = ST_R_SQRT_LD;
      end
      ST_R_SQRT_LD: begin
        cmd.op     = OP_SQRT_LD;
        state_next = ST_R_SQRT;
      end
      ST_R_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (status.iter_last) state_next = ST_SET_R;
      end
      ST_SET_R: begin
        cmd.op     = OP_SET_R;
        state_next = ST_SPEED_INIT;
      end
      ST_SPEED_INIT: begin
        cmd.op     = OP_SPEED_INIT;
        state_next = ST_STEP_CHECK;
      end
      ST_STEP_CHECK: begin
        state_next = status.step_end ? ST_EMIT : ST_MUL_OX;
      end
      ST_MUL_OX: begin
        cmd.op     = OP_MUL_OX;
        state_next = ST_DIV_OX_LD;
      end
      ST_DIV_OX_LD: begin
        cmd.op     = OP_DIV_LD;
        state_next = ST_DIV_OX;
      end
      ST_DIV_OX: begin
        cmd.op = OP_DIV_STEP;
        if (status.iter_last) state_next = ST_SET_OX;
      end
      ST_SET_OX: begin
        cmd.op     = OP_SET_OX;
        state_next = ST_DIV_OY_LD;
      end
      ST_DIV_OY_LD: begin
        cmd.op     = OP_DIV_LD;
        state_next = ST_DIV_OY;
      end
      ST_DIV_OY: begin
        cmd.op = OP_DIV_STEP;
        if (status.iter_last) state_next = ST_SET_OY;
      end
      ST_SET_OY: begin
        cmd.op     = OP_SET_OY;
        state_next = ST_CONTACT;
      end
      ST_CONTACT: begin
        cmd.op     = OP_CONTACT;
        state_next = status.slot_ok ? ST_MUL_V : ST_NEXT;
      end
      ST_MUL_V: begin
        cmd.op     = OP_MUL_V;
        state_next = ST_MUL_MX;
      end
      ST_MUL_MX: begin
        cmd.op     = OP_MUL_MX;
        state_next = ST_MUL_MY;
      end
      ST_MUL_MY: begin
        cmd.op     = OP_MUL_MY;
        state_next = ST_DELTA;
      end
      ST_DELTA: begin
        cmd.op     = OP_DELTA;
        state_next = ST_DELTA_Y;
      end
      ST_DELTA_Y: begin
        cmd.op     = OP_DELTA_Y;
        state_next = ST_SQ_AX;
      end
      ST_SQ_AX: begin
        cmd.op     = OP_SQ_AX;
        state_next = status.in_box ? ST_SQ_AY : ST_NEXT;
      end
      ST_SQ_AY: begin
        cmd.op     = OP_SQ_AY;
        state_next = ST_C_SQRT_LD;
      end
      ST_C_SQRT_LD: begin
        cmd.op     = OP_SQRT_LD;
        state_next = ST_C_SQRT;
      end
      ST_C_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (status.iter_last) state_next = ST_RNG_UPDATE;
      end
      ST_RNG_UPDATE: begin
        cmd.op     = OP_RNG_UPDATE;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.op     = OP_NEXT;
        state_next = status.last_contact ? ST_STEP_ADV : ST_CONTACT;
      end
      ST_STEP_ADV: begin
        cmd.op     = OP_STEP_ADV;
        state_next = ST_STEP_CHECK;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = status.last_speed ? ST_IDLE : ST_SPEED_INIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> sv/cdss_dp.sv
// Datapath of the contact density speed sweep: contact slots, shared multiplier,
// serial divider and square root unit, step counters and result register.
// Depends on cdss_pkg; executes cmd_t from cdss_ctrl and returns status_t.
module cdss_dp import cdss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  cfg_t                  cfg,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output status_t               status
);

  logic [MAX_CONTACTS-1:0] slot_valid;
  logic signed [31:0]      stored_x       [MAX_CONTACTS];
  logic signed [31:0]      stored_y       [MAX_CONTACTS];
  logic [8:0]              stored_heading [MAX_CONTACTS];
  logic [15:0]             stored_speed   [MAX_CONTACTS];

  logic [5:0]  t_c;
  logic [13:0] d_c;
  logic [6:0]  m_c;
  logic [21:0] cap;
  logic [13:0] t256;
  logic [30:0] qt_prod;
  logic [10:0] qt;
  logic [13:0] qt10;
  logic [3:0]  rt;

  logic signed [32:0] gdx, gdy;
  logic [32:0]        gax, gay;

  logic        gx_neg, gy_neg;
  logic [30:0] gmx, gmy;
  logic [63:0] p, acc;
  logic [63:0] sq_n, sq_r, sq_b, sq_rb;
  logic [4:0]  iter;
  logic [31:0] rr;
  logic [35:0] r10;
  logic [31:0] dv_rem, dv_lo;
  logic [32:0] dv_sh;

  logic [6:0]       j;
  logic [PJ_W-1:0]  pj;
  logic [19:0]      a_q;
  logic [3:0]       a_r;
  logic [I_W-1:0]   i;
  logic [IT_W-1:0]  it;
  logic [ITJ_W-1:0] itj;
  logic [31:0]      l;
  logic [3:0]       lr;
  logic [4:0]       lr_sum, ar_sum;

  logic signed [33:0] ox, oy;
  logic [K_W-1:0]     k;
  logic [4:0]         count, peak, closest;
  logic [21:0]        min_cpa;

  logic signed [31:0] cx, cy;
  logic [8:0]         ch;
  logic [15:0]        cspd;
  trig_t              sin_t, cos_t;
  logic [33:0]        v;
  logic [34:0]        mvx, mvy;
  logic [37:0]        ax, ay;
  logic signed [37:0] ex, ey, mvx_s, mvy_s;
  logic [22:0]        rng;

  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] mul_full;

  always_comb begin
    t_c = cfg.time_step_s;
    if (t_c == 6'd0) t_c = 6'd1;
    else if (t_c > 6'(T_MAX)) t_c = 6'(T_MAX);
    d_c = cfg.density_range_m;
    if (d_c == 14'd0) d_c = 14'd1;
    else if (d_c > 14'(D_MAX)) d_c = 14'(D_MAX);
    m_c = cfg.max_speed_tenths;
    if (m_c == 7'd0) m_c = 7'd1;
    else if (m_c > 7'(M_MAX)) m_c = 7'(M_MAX);
  end

  assign cap     = {d_c, 8'd0};
  assign t256    = {t_c, 8'd0};
  assign qt_prod = 31'(t256) * 31'd52429;
  assign qt      = qt_prod[29:19];
  assign qt10    = 14'(qt) * 14'd10;
  assign rt      = 4'(t256 - qt10);

  assign gdx = 33'(cfg.goal_x) - 33'(cfg.own_x);
  assign gdy = 33'(cfg.goal_y) - 33'(cfg.own_y);
  assign gax = gdx[32] ? 33'(-gdx) : 33'(gdx);
  assign gay = gdy[32] ? 33'(-gdy) : 33'(gdy);

  always_comb begin
    case (cmd.op)
      OP_SQ_GX:  begin mul_a = 34'(gmx);       mul_b = 32'(gmx);       end
      OP_SQ_GY:  begin mul_a = 34'(gmy);       mul_b = 32'(gmy);       end
      OP_MUL_OX: begin mul_a = 34'(gmx);       mul_b = l;              end
      OP_SET_OX: begin mul_a = 34'(gmy);       mul_b = l;              end
      OP_MUL_V:  begin mul_a = 34'(it);        mul_b = 32'(cspd);      end
      OP_MUL_MX: begin mul_a = p[33:0];        mul_b = 32'(sin_t.mag); end
      OP_MUL_MY: begin mul_a = v;              mul_b = 32'(cos_t.mag); end
      OP_SQ_AX:  begin mul_a = 34'(ax[21:0]);  mul_b = 32'(ax[21:0]);  end
      OP_SQ_AY:  begin mul_a = 34'(ay[21:0]);  mul_b = 32'(ay[21:0]);  end
      default:   begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  assign mul_full = 66'(mul_a) * 66'(mul_b);
  assign sq_rb    = sq_r + sq_b;
  assign dv_sh    = {dv_rem, dv_lo[31]};
  assign lr_sum   = 5'(lr) + 5'(a_r);
  assign ar_sum   = 5'(a_r) + 5'(rt);
  assign rng      = sq_r[22:0];

  assign mvx_s = $signed({3'b000, mvx});
  assign mvy_s = $signed({3'b000, mvy});
  assign ex    = 38'(cx) + (sin_t.neg ? -mvx_s : mvx_s) - 38'(ox);
  assign ey    = 38'(cy) + (cos_t.neg ? -mvy_s : mvy_s) - 38'(oy);

  assign status.iter_last    = (iter == 5'd31);
  assign status.step_end     = ({4'd0, itj, 8'd0} >= 36'(r10)) ||
                               (i > I_W'(MAX_SIM_STEPS));
  assign status.slot_ok      = slot_valid[k];
  assign status.in_box       = (ax < 38'(cap)) && (ay < 38'(cap));
  assign status.last_contact = (k == K_W'(MAX_CONTACTS - 1));
  assign status.last_speed   = (j == m_c);
  assign status.out_free     = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.op == OP_LOAD && 32'(in_data[3:0]) < 32'(MAX_CONTACTS)) begin
      slot_valid[in_data[K_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && 32'(in_data[3:0]) < 32'(MAX_CONTACTS)) begin
      stored_x[in_data[K_W-1:0]]       <= in_data[35:4];
      stored_y[in_data[K_W-1:0]]       <= in_data[67:36];
      stored_heading[in_data[K_W-1:0]] <= in_data[76:68];
      stored_speed[in_data[K_W-1:0]]   <= in_data[92:77];
    end
    if (cmd.op == OP_CONTACT) begin
      cx   <= stored_x[k];
      cy   <= stored_y[k];
      ch   <= stored_heading[k];
      cspd <= stored_speed[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQ_GX, OP_MUL_OX, OP_MUL_V, OP_SQ_AX: begin
        p <= mul_full[63:0];
      end
      OP_SQ_GY, OP_SQ_AY: begin
        acc <= p;
        p   <= mul_full[63:0];
      end
      OP_START: begin
        gx_neg <= gdx[32];
        gy_neg <= gdy[32];
        gmx    <= (gax > 33'h07FFFFFFF) ? 31'h7FFFFFFF : gax[30:0];
        gmy    <= (gay > 33'h07FFFFFFF) ? 31'h7FFFFFFF : gay[30:0];
      end
      OP_SQRT_LD: begin
        sq_n <= acc + p;
        sq_r <= '0;
        sq_b <= 64'd1 << 62;
        iter <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_n >= sq_rb) begin
          sq_n <= sq_n - sq_rb;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
        iter <= iter + 5'd1;
      end
      OP_SET_R: begin
        rr  <= sq_r[31:0];
        r10 <= ({4'd0, sq_r[31:0]} << 3) + ({4'd0, sq_r[31:0]} << 1);
        j   <= 7'd1;
        pj  <= PJ_W'(t_c);
        a_q <= 20'(qt);
        a_r <= rt;
      end
      OP_SPEED_INIT: begin
        peak    <= '0;
        closest <= NO_SLOT;
        min_cpa <= cap;
        i       <= I_W'(1);
        it      <= IT_W'(t_c);
        itj     <= ITJ_W'(pj);
        l       <= 32'(a_q);
        lr      <= a_r;
      end
      OP_DIV_LD: begin
        dv_rem <= p[63:32];
        dv_lo  <= p[31:0];
        iter   <= '0;
      end
      OP_DIV_STEP: begin
        if (dv_sh >= {1'b0, rr}) begin
          dv_rem <= 32'(dv_sh - {1'b0, rr});
          dv_lo  <= {dv_lo[30:0], 1'b1};
        end else begin
          dv_rem <= dv_sh[31:0];
          dv_lo  <= {dv_lo[30:0], 1'b0};
        end
        iter <= iter + 5'd1;
      end
      OP_SET_OX: begin
        ox <= gx_neg ? 34'(cfg.own_x) - $signed({2'b00, dv_lo})
                     : 34'(cfg.own_x) + $signed({2'b00, dv_lo});
        p  <= mul_full[63:0];
      end
      OP_SET_OY: begin
        oy    <= gy_neg ? 34'(cfg.own_y) - $signed({2'b00, dv_lo})
                        : 34'(cfg.own_y) + $signed({2'b00, dv_lo});
        k     <= '0;
        count <= '0;
      end
      OP_MUL_MX: begin
        v     <= p[33:0];
        p     <= mul_full[63:0];
      end
      OP_MUL_MY: begin
        mvx <= p[48:14];
        p   <= mul_full[63:0];
      end
      OP_DELTA: begin
        mvy <= p[48:14];
        ax  <= ex[37] ? 38'(-ex) : 38'(ex);
      end
      OP_DELTA_Y: begin
        ay <= ey[37] ? 38'(-ey) : 38'(ey);
      end
      OP_RNG_UPDATE: begin
        if (rng < 23'(cap)) count <= count + 5'd1;
        if (rng < 23'(min_cpa)) begin
          min_cpa <= rng[21:0];
          closest <= 5'(k);
        end
      end
      OP_NEXT: begin
        k <= k + K_W'(1);
      end
      OP_STEP_ADV: begin
        if (count > peak) peak <= count;
        i   <= i + I_W'(1);
        it  <= it + IT_W'(t_c);
        itj <= itj + ITJ_W'(pj);
        if (lr_sum >= 5'd10) begin
          lr <= 4'(lr_sum - 5'd10);
          l  <= l + 32'(a_q) + 32'd1;
        end else begin
          lr <= lr_sum[3:0];
          l  <= l + 32'(a_q);
        end
      end
      OP_EMIT: begin
        m_tdata <= {1'b0, min_cpa, closest, peak, j};
        m_tlast <= (j == m_c);
        j       <= j + 7'd1;
        pj      <= pj + PJ_W'(t_c);
        if (ar_sum >= 5'd10) begin
          a_r <= 4'(ar_sum - 5'd10);
          a_q <= a_q + 20'(qt) + 20'd1;
        end else begin
          a_r <= ar_sum[3:0];
          a_q <= a_q + 20'(qt);
        end
      end
      default: ;
    endcase
    if (cmd.op == OP_MUL_V) begin
      sin_t <= sin_deg({1'b0, ch});
      cos_t <= sin_deg({1'b0, ch} + 10'd90);
    end
  end

endmodule

>>> sv/contact_density_speed_sweep.sv
// Top level of the contact density speed sweep: APB registers, sequencer and datapath.
// Depends on cdss_pkg, cdss_regs, cdss_ctrl and cdss_dp.
//
// A contact word (tuser 0) is taken while the sequencer is idle, one per cycle back to back.
// A run word (tuser 1) starts a sweep that holds the input until the last result
// is issued. Run setup squares the goal offsets and takes one serial square root.
// For each speed, every simulated step runs two serial divides that place own
// ship and then visits every slot: an empty slot is skipped, a contact outside
// the density box is dropped after the box check, and one inside takes a serial
// square root of its range. Results leave through a one-word output register,
// so the sweep only waits when that register is still full.
module contact_density_speed_sweep import cdss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // slot[3:0], x[35:4], y[67:36], heading[76:68], speed[92:77], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // speed_tenths[6:0], peak_count[11:7], closest_slot[16:12], min_cpa[38:17], pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  cdss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  cdss_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .status   (status)
  );

endmodule

>>> test/tb_contact_density_speed_sweep.sv
// Testbench for contact_density_speed_sweep: loads contacts, runs speed sweeps and checks
// every result word against an in-bench sweep predictor. Depends on cdss_pkg and the RTL.
module tb_contact_density_speed_sweep;
  import cdss_pkg::*;

  typedef struct {
    logic [6:0]  speed;
    logic [4:0]  peak;
    logic [4:0]  slot;
    logic [21:0] cpa;
    logic        last;
  } sweep_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  contact_density_speed_sweep u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic        slot_used [MAX_CONTACTS];
  logic [31:0] slot_x [MAX_CONTACTS];
  logic [31:0] slot_y [MAX_CONTACTS];
  logic [8:0]  slot_hdg [MAX_CONTACTS];
  logic [15:0] slot_spd [MAX_CONTACTS];
  logic [31:0] cfg_own_x = 0, cfg_own_y = 0, cfg_goal_x = 0, cfg_goal_y = 0;
  logic [5:0]  cfg_tstep = 6'd1;
  logic [13:0] cfg_range = 14'd50;
  logic [6:0]  cfg_maxspd = 7'd50;

  sweep_res_t pending_res[$];
  int errors = 0;
  int n_contacts = 0, n_runs = 0, n_results = 0;
  int rdy_wait = 0;
  bit no_idle = 0;

  function automatic longint unsigned isqrt_u64(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_u(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint clip31(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  function automatic int quarter_sine(int unsigned d);
    longint unsigned x, x2, t;
    x  = longint'(d) * 64'd18740330;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    return int'((((x * t) >> 30) + (64'd1 << 15)) >> 16);
  endfunction

  function automatic int heading_sine(int unsigned h);
    h = h % 360;
    if (h <= 90) return quarter_sine(h);
    if (h <= 180) return quarter_sine(180 - h);
    if (h <= 270) return -quarter_sine(h - 180);
    return -quarter_sine(360 - h);
  endfunction

  function automatic longint drift(longint unsigned v, int s);
    if (s < 0) return -longint'((v * longint'(-s)) >> 14);
    return longint'((v * longint'(s)) >> 14);
  endfunction

  function automatic longint toward_goal(longint g, longint unsigned travel,
                                         longint unsigned r);
    longint unsigned q;
    q = (abs_u(g) * travel) / r;
    return g < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_sweep();
    int unsigned t, d, m;
    longint gx, gy, ox, oy, ox0, oy0;
    longint unsigned r, cap, prod, travel, v, ax, ay, rng, min_r;
    int vs [MAX_CONTACTS];
    int vc [MAX_CONTACTS];
    int unsigned peak, cnt, best;
    sweep_res_t e;
    t = cfg_tstep < 1 ? 1 : (cfg_tstep > 60 ? 60 : cfg_tstep);
    d = cfg_range < 1 ? 1 : (cfg_range > 10000 ? 10000 : cfg_range);
    m = cfg_maxspd < 1 ? 1 : (cfg_maxspd > 64 ? 64 : cfg_maxspd);
    ox0 = longint'($signed(cfg_own_x));
    oy0 = longint'($signed(cfg_own_y));
    gx = clip31(longint'($signed(cfg_goal_x)) - ox0);
    gy = clip31(longint'($signed(cfg_goal_y)) - oy0);
    r = isqrt_u64(abs_u(gx) * abs_u(gx) + abs_u(gy) * abs_u(gy));
    cap = longint'(d) * 256;
    for (int k = 0; k < MAX_CONTACTS; k++) begin
      vs[k] = heading_sine(slot_hdg[k]);
      vc[k] = heading_sine(slot_hdg[k] + 90);
    end
    for (int unsigned j = 1; j <= m; j++) begin
      peak = 0;
      best = NO_SLOT;
      min_r = cap;
      for (longint unsigned i = 1; i <= MAX_SIM_STEPS; i++) begin
        prod = i * t * j * 256;
        if (prod >= 10 * r) break;
        travel = prod / 10;
        ox = ox0 + toward_goal(gx, travel, r);
        oy = oy0 + toward_goal(gy, travel, r);
        cnt = 0;
        for (int k = 0; k < MAX_CONTACTS; k++) begin
          if (!slot_used[k]) continue;
          v = i * t * slot_spd[k];
          ax = abs_u(longint'($signed(slot_x[k])) + drift(v, vs[k]) - ox);
          ay = abs_u(longint'($signed(slot_y[k])) + drift(v, vc[k]) - oy);
          if (ax >= cap || ay >= cap) continue;
          rng = isqrt_u64(ax * ax + ay * ay);
          if (rng < cap) cnt++;
          if (rng < min_r) begin
            min_r = rng;
            best = k;
          end
        end
        if (cnt > peak) peak = cnt;
      end
      e.speed = 7'(j);
      e.peak = 5'(peak);
      e.slot = 5'(best);
      e.cpa = 22'(min_r);
      e.last = (j == m);
      pending_res.push_back(e);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker and receiver pacing
  always @(posedge clk) begin
    sweep_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      rdy_wait = no_idle ? 0 : $urandom_range(0, 14);
      if (pending_res.size() == 0) report("unexpected word", m_tdata[6:0], 0);
      else begin
        e = pending_res.pop_front();
        if (m_tdata[6:0] !== e.speed) report("speed_tenths", m_tdata[6:0], e.speed);
        if (m_tdata[11:7] !== e.peak) report("peak_count", m_tdata[11:7], e.peak);
        if (m_tdata[16:12] !== e.slot) report("closest_slot", m_tdata[16:12], e.slot);
        if (m_tdata[38:17] !== e.cpa) report("min_cpa", m_tdata[38:17], e.cpa);
        if (m_tlast !== e.last) report("last", m_tlast, e.last);
      end
    end
  end

  always @(negedge clk) begin
    if (rdy_wait > 0) begin
      m_tready <= 1'b0;
      rdy_wait--;
    end else m_tready <= 1'b1;
  end

  task automatic send_word(bit op, logic [3:0] slot, logic [31:0] x, logic [31:0] y,
                           logic [8:0] hdg, logic [15:0] spd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'b0, spd, hdg, y, x, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op) begin
      n_runs++;
      predict_sweep();
    end else begin
      n_contacts++;
      slot_used[slot] = 1'b1;
      slot_x[slot] = x;
      slot_y[slot] = y;
      slot_hdg[slot] = hdg;
      slot_spd[slot] = spd;
    end
  endtask

  task automatic hold_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    hold_input();
    while (pending_res.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_OWN_X:     cfg_own_x = val;
      REG_OWN_Y:     cfg_own_y = val;
      REG_GOAL_X:    cfg_goal_x = val;
      REG_GOAL_Y:    cfg_goal_y = val;
      REG_TIME_STEP: cfg_tstep = val[5:0];
      REG_DENSITY:   cfg_range = val[13:0];
      REG_MAX_SPEED: cfg_maxspd = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_course(logic [31:0] ox, logic [31:0] oy, logic [31:0] gx, logic [31:0] gy);
    cfg_write(REG_OWN_X, ox);
    cfg_write(REG_OWN_Y, oy);
    cfg_write(REG_GOAL_X, gx);
    cfg_write(REG_GOAL_Y, gy);
  endtask

  task automatic run_sweep();
    send_word(1'b1, 4'($urandom), $urandom, $urandom, 9'($urandom_range(0, 359)),
              16'($urandom));
    drain();
  endtask

  task automatic test_empty_runs();
    run_sweep();
    cfg_write(REG_MAX_SPEED, 0);
    set_course(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    run_sweep();
  endtask

  task automatic test_directed_contacts();
    int hdgs [5] = '{0, 90, 180, 270, 359};
    set_course(32'sd1024, -32'sd512, 32'sd1024 + 32'sd768, -32'sd512 + 32'sd256);
    cfg_write(REG_TIME_STEP, 1);
    cfg_write(REG_DENSITY, 3);
    cfg_write(REG_MAX_SPEED, 3);
    send_word(1'b0, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 9'd0, 16'hffff);
    send_word(1'b0, 4'd15, 32'h8000_0000, 32'h7fff_ffff, 9'd359, 16'd0);
    for (int k = 0; k < 5; k++)
      send_word(1'b0, 4'(k + 1), 32'sd1024 + k * 64, -32'sd512 + k * 32, 9'(hdgs[k]),
                16'd64);
    send_word(1'b0, 4'd6, 32'sd1024, -32'sd512, 9'd45, 16'd0);
    send_word(1'b0, 4'd7, 32'sd1024, -32'sd512, 9'd200, 16'd0);
    run_sweep();
  endtask

  task automatic test_reg_limits();
    cfg_write(REG_TIME_STEP, 63);
    cfg_write(REG_MAX_SPEED, 127);
    run_sweep();
    cfg_write(REG_TIME_STEP, 0);
    cfg_write(REG_DENSITY, 16383);
    cfg_write(REG_MAX_SPEED, 2);
    run_sweep();
    cfg_write(REG_DENSITY, 0);
    cfg_write(REG_TIME_STEP, 60);
    cfg_write(REG_MAX_SPEED, 64);
    run_sweep();
    cfg_write(REG_DENSITY, 10000);
    cfg_write(REG_TIME_STEP, 1);
    cfg_write(REG_MAX_SPEED, 1);
    run_sweep();
  endtask

  task automatic test_random_sweeps();
    logic [31:0] bx, by;
    int span, loads;
    for (int p = 0; p < 16; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      bx = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
      by = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
      set_course(bx, by, bx + $urandom_range(0, 1024) - 512, by + $urandom_range(0, 1024) - 512);
      cfg_write(REG_TIME_STEP, $urandom_range(1, 5));
      cfg_write(REG_DENSITY, $urandom_range(1, 12));
      cfg_write(REG_MAX_SPEED, $urandom_range(1, 6));
      span = 16 * 256;
      loads = $urandom_range(3, 9);
      for (int k = 0; k < loads; k++)
        send_word(1'b0, 4'($urandom), bx + $urandom_range(0, 2 * span) - span,
                  by + $urandom_range(0, 2 * span) - span, 9'($urandom_range(0, 359)),
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512)));
      run_sweep();
    end
    no_idle = 0;
  endtask

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int k = 0; k < MAX_CONTACTS; k++) begin
      slot_used[k] = 1'b0;
      slot_x[k] = 0;
      slot_y[k] = 0;
      slot_hdg[k] = 0;
      slot_spd[k] = 0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    repeat (5) @(negedge clk);
    test_empty_runs();
    test_directed_contacts();
    test_reg_limits();
    test_random_sweeps();
    $display("covered %0d contact loads and %0d sweeps, %0d result words checked",
             n_contacts, n_runs, n_results);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> contact_density_speed_sweep.f
sv/cdss_pkg.sv
sv/cdss_regs.sv
sv/cdss_ctrl.sv
sv/cdss_dp.sv
sv/contact_density_speed_sweep.sv
test/tb_contact_density_speed_sweep.sv
